/* src/rotor_substitution_stepper_assert.svh */
// Assertion macros for the rotor substitution stepper.
`ifndef ROTOR_SUBSTITUTION_STEPPER_ASSERT_SVH
`define ROTOR_SUBSTITUTION_STEPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rotor stepper check failed");

// Consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rotor stepper check failed");

`endif

/* src/rss_pkg.sv */
// Types and constants shared by the rotor substitution stepper.
package rss_pkg;

    localparam int ALPHA_N   = 26;
    localparam int LETTER_W  = 5;
    localparam int NOTCH_W   = 26;
    localparam int CFG_W     = 26;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_N - 1);
    localparam logic [LETTER_W-1:0] ALPHA_N5    = LETTER_W'(ALPHA_N);
    localparam logic [LETTER_W:0]   ALPHA_N6    = (LETTER_W+1)'(ALPHA_N);
    localparam logic [LETTER_W:0]   ALPHA_2N6   = (LETTER_W+1)'(2 * ALPHA_N);

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_REV  = 2'd2,
        MODE_STEP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DUP   = 2'd2
    } t_status;

    typedef enum logic {
        REG_START_POSITION = 1'b0,
        REG_NOTCH_MASK     = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]          mode;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] wiring_value;
    } t_in_word;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_out;
        logic                at_notch;
        logic [1:0]          status;
    } t_out_word;

    // Reduce a value below 2N into 0..N-1.
    function automatic logic [LETTER_W-1:0] fold_once(input logic [LETTER_W:0] v);
        logic [LETTER_W:0] r;
        r = (v >= ALPHA_N6) ? (v - ALPHA_N6) : v;
        return r[LETTER_W-1:0];
    endfunction

endpackage

/* src/rotor_substitution_stepper.sv */
// Rotor substitution stepper: wiring memories, rotation offset and result pipeline.
//
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_ready      i_in_word  (t_in_word)
//  out       source     o_out_valid / i_out_ready    o_out_word (t_out_word)
//  cfg       sink       i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One word per cycle while the output is not stalled; each accepted word passes
// through the memory read stage, then the output register. Loads write both
// wiring memories and the inverse valid bits at acceptance, so a following map
// sees them. Synchronous active-low reset clears the offset, registers, valid
// bits and pipeline; the wiring memories are not cleared. A stalled output
// holds the read stage, and o_in_ready drops only when both stages are full.
`include "rotor_substitution_stepper_assert.svh"

module rotor_substitution_stepper
    import rss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    // Architectural state
    logic [LETTER_W-1:0] r_offset;
    logic [NOTCH_W-1:0]  r_notch_mask;
    logic [ALPHA_N-1:0]  r_inv_valid;
    logic [LETTER_W-1:0] r_fwd_mem [ALPHA_N];
    logic [LETTER_W-1:0] r_inv_mem [ALPHA_N];

    // Read stage
    logic                r_s1_valid;
    t_mode               r_s1_mode;
    logic [LETTER_W-1:0] r_s1_offset;
    logic                r_s1_notch;
    t_status             r_s1_status;
    logic                r_s1_inv_hit;
    logic [LETTER_W-1:0] r_fwd_rd;
    logic [LETTER_W-1:0] r_inv_rd;

    // Output stage
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                accept;
    logic                s1_advance;
    t_mode               in_mode;
    logic [LETTER_W:0]   idx_sum;
    logic [LETTER_W-1:0] idx;
    logic                in_range;
    logic                dup_hit;
    logic                load_ok;
    t_status             in_status;
    logic [LETTER_W-1:0] offset_step;
    logic [LETTER_W-1:0] offset_after;
    logic                notch_after;
    logic [LETTER_W-1:0] n_offset;
    logic [LETTER_W-1:0] map_raw;
    logic [LETTER_W-1:0] map_val;
    logic [LETTER_W-1:0] map_res;
    t_out_word           n_out_word;

    assign s1_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Decode and address stage
    always_comb begin
        in_mode = t_mode'(i_in_word.mode);
        idx_sum = {1'b0, i_in_word.letter} + {1'b0, r_offset};
        if (idx_sum >= ALPHA_2N6) begin
            idx = LETTER_W'(idx_sum - ALPHA_2N6);
        end else begin
            idx = fold_once(idx_sum);
        end
        in_range = (i_in_word.wiring_value < ALPHA_N5) && (i_in_word.letter < ALPHA_N5);
        dup_hit  = in_range && r_inv_valid[i_in_word.wiring_value];
        load_ok  = (in_mode == MODE_LOAD) && in_range && !dup_hit;
        if (in_mode != MODE_LOAD) begin
            in_status = ST_OK;
        end else if (!in_range) begin
            in_status = ST_RANGE;
        end else if (dup_hit) begin
            in_status = ST_DUP;
        end else begin
            in_status = ST_OK;
        end
        offset_step  = (r_offset == LAST_LETTER) ? '0 : r_offset + 1'b1;
        offset_after = (in_mode == MODE_STEP) ? offset_step : r_offset;
        notch_after  = (offset_after < ALPHA_N5) ? r_notch_mask[offset_after] : 1'b0;
    end

    // Offset: a start position write wins over a step
    always_comb begin
        n_offset = r_offset;
        if (i_cfg_we && (t_cfg_reg'(i_cfg_idx) == REG_START_POSITION)) begin
            n_offset = fold_once({1'b0, i_cfg_data[LETTER_W-1:0]});
        end else if (accept && (in_mode == MODE_STEP)) begin
            n_offset = offset_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_notch_mask <= '0;
            r_inv_valid  <= '0;
        end else begin
            r_offset <= n_offset;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_START_POSITION: ;
                    REG_NOTCH_MASK:     r_notch_mask <= i_cfg_data[NOTCH_W-1:0];
                endcase
            end
            if (accept && load_ok) begin
                r_inv_valid[i_in_word.wiring_value] <= 1'b1;
            end
        end
    end

    // Wiring memories: write on an accepted load, read on every accepted word
    always_ff @(posedge i_clk) begin
        if (accept && load_ok) begin
            r_fwd_mem[i_in_word.letter]       <= i_in_word.wiring_value;
            r_inv_mem[i_in_word.wiring_value] <= i_in_word.letter;
        end
        if (accept) begin
            r_fwd_rd <= r_fwd_mem[idx];
            r_inv_rd <= r_inv_mem[idx];
        end
    end

    // Read stage sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !s1_advance);
        end
        if (accept) begin
            r_s1_mode    <= in_mode;
            r_s1_offset  <= r_offset;
            r_s1_notch   <= notch_after;
            r_s1_status  <= in_status;
            r_s1_inv_hit <= r_inv_valid[idx];
        end
    end

    // Undo the rotation on the looked-up letter
    always_comb begin
        if (r_s1_mode == MODE_FWD) begin
            map_raw = r_fwd_rd;
        end else begin
            map_raw = r_s1_inv_hit ? r_inv_rd : '0;
        end
        map_val = fold_once({1'b0, map_raw});
        map_res = fold_once({1'b0, map_val} + ALPHA_N6 - {1'b0, r_s1_offset});
        n_out_word.at_notch = r_s1_notch;
        n_out_word.status   = r_s1_status;
        unique case (r_s1_mode)
            MODE_FWD, MODE_REV:   n_out_word.letter_out = map_res;
            MODE_LOAD, MODE_STEP: n_out_word.letter_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s1_advance || (r_out_valid && !i_out_ready);
        end
        if (s1_advance) begin
            r_out_word <= n_out_word;
        end
    end

    `RSS_ASSERT_NOW(a_offset_in_range, i_clk, i_rst_n, 1'b1, r_offset < ALPHA_N5)
    `RSS_ASSERT_NEXT(a_step_advances, i_clk, i_rst_n,
        accept && (in_mode == MODE_STEP) && !i_cfg_we,
        r_offset == (($past(r_offset) == LAST_LETTER) ? '0 : $past(r_offset) + 1'b1))
    `RSS_ASSERT_NEXT(a_load_marks_target, i_clk, i_rst_n,
        accept && load_ok, r_inv_valid[$past(i_in_word.wiring_value)])
    `RSS_ASSERT_NOW(a_full_blocks_input, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready)

endmodule
